### src/brf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg
// shared constants for the byte ring fifo: request codes, widths and the
// field layout of the stream words
// ----------------------------------------------------------------------------
package brf_pkg;

  // defaults for the top level parameters
  localparam int DEPTH_DEF    = 256;
  localparam int MAX_PEEK_DEF = 64;

  // field widths
  localparam int BYTE_W = 8;
  localparam int REQ_W  = 3;
  localparam int CNT_F_W = 9;   // capacity, amount, done_count, level

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DROP  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

  // input tdata layout
  localparam int IN_TDATA_W  = 24;
  localparam int ID_BYTE_LSB = 0;
  localparam int ID_AMT_LSB  = 8;

  // output tdata layout
  localparam int OUT_TDATA_W  = 32;
  localparam int OD_BYTE_LSB  = 0;
  localparam int OD_OK        = 8;
  localparam int OD_DONE_LSB  = 9;
  localparam int OD_LEVEL_LSB = 18;
  localparam int OD_FULL      = 27;
  localparam int OD_EMPTY     = 28;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

endpackage
`default_nettype wire

### src/brf_wrap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_wrap
// shared pointer unit: adds a step to a ring pointer and wraps at the limit
// ----------------------------------------------------------------------------
module brf_wrap #(
  parameter int PTR_W = 8,
  parameter int CNT_W = 9
) (
  input  wire logic [PTR_W-1:0] base,
  input  wire logic [CNT_W-1:0] step,
  input  wire logic [CNT_W-1:0] limit,
  output logic      [PTR_W-1:0] res
);

  logic [CNT_W:0] sum;
  logic [CNT_W:0] wrapped;

  // base stays below the limit and step does not exceed it, so one subtract is enough
  always_comb begin
    sum     = (CNT_W+1)'(base) + (CNT_W+1)'(step);
    wrapped = (sum >= (CNT_W+1)'(limit)) ? sum - (CNT_W+1)'(limit) : sum;
    res     = wrapped[PTR_W-1:0];
  end

endmodule
`default_nettype wire

### src/byte_ring_fifo_with_peek_drop.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_peek_drop
// byte ring fifo with configurable capacity, push, pop, peek run, drop, clear
// ----------------------------------------------------------------------------
// One request enters per input transfer (tuser = request kind) and the block
// stays not ready until every result of that request has been transferred
// out. Push, drop, clear and unknown kinds give one result after the work
// states accept, length and action. Pop goes on from action to a wait for
// the registered storage read before its result. A peek of n bytes gives n
// results: the first one after the registered read, each further one through
// address, read and transfer; an empty peek gives a single result. These
// steps come from the single read port of the storage array and the one wrap
// adder that every pointer step and peek address goes through. Writing the
// capacity register empties the fifo; capacity 0 acts as 1 and values above
// DEPTH act as DEPTH. Storage has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_peek_drop #(
  parameter int DEPTH    = brf_pkg::DEPTH_DEF,
  parameter int MAX_PEEK = brf_pkg::MAX_PEEK_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // tdata: push_byte [7:0], amount [16:8], zero fill above
  input  wire logic [brf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: req_type [2:0]
  input  wire logic [brf_pkg::REQ_W-1:0]       in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // tdata: read_byte [7:0], ok [8], done_count [17:9], level [26:18],
  //        full_res [27], empty_res [28], zero fill above
  output logic [brf_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast,
  // configuration port
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [brf_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [brf_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [brf_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                 cfg_pready
);

  import brf_pkg::*;

  // widths that follow from the parameters
  localparam int PTR_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int CW = (FILL_W > CNT_F_W) ? FILL_W : CNT_F_W;
  localparam int IDX_W = (MAX_PEEK > 1) ? $clog2(MAX_PEEK) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] MAXP_C = CW'(MAX_PEEK);
  localparam logic [CW-1:0] RST_ECAP = (DEPTH < 256) ? CW'(DEPTH) : CW'(256);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LEN  = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_ADDR = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // control state
  logic [2:0]         state_r, state_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CNT_F_W-1:0] cap_r, cap_nxt;
  logic [CW-1:0]      ecap_r, ecap_nxt;
  logic               out_valid_r, out_valid_nxt;

  // request held for its whole run
  logic [REQ_W-1:0]   req_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [CNT_F_W-1:0] amt_r;
  logic [CW-1:0]      len_r, len_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  // result register
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_last_r;

  // storage
  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;
  logic              mem_we;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_raddr;

  // shared wrap unit
  logic [PTR_W-1:0] unit_base;
  logic [CW-1:0]    unit_step;
  logic [PTR_W-1:0] unit_res;

  // result load
  logic                   ld;
  logic [BYTE_W-1:0]      ld_byte;
  logic                   ld_ok;
  logic [CW-1:0]          ld_done;
  logic                   ld_last;
  logic [OUT_TDATA_W-1:0] ld_word;

  logic          in_xfer;
  logic          out_xfer;
  logic          cfg_wr;
  logic [CW-1:0] wcap;
  logic [CW-1:0] amt_ext;
  logic          at_last;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_xfer   = out_valid_r & out_tready;

  // apb: single register at byte address 0, no wait states
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & ~cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? '0 : CFG_DATA_W'(cap_r);
  assign wcap       = CW'(cfg_pwdata[CNT_F_W-1:0]);

  assign amt_ext = CW'(amt_r);
  assign at_last = ((CW'(idx_r) + CW'(1)) == len_r);

  brf_wrap #(
    .PTR_W (PTR_W),
    .CNT_W (CW)
  ) u_wrap (
    .base  (unit_base),
    .step  (unit_step),
    .limit (ecap_r),
    .res   (unit_res)
  );

  // operand select for the wrap unit
  always_comb begin
    unit_base = rp_r;
    unit_step = CW'(1);
    case (state_r)
      S_ACT: begin
        case (req_r)
          REQ_PUSH: unit_base = wp_r;
          REQ_DROP: unit_step = len_r;
          default:  unit_base = rp_r;
        endcase
      end
      S_ADDR:  unit_step = CW'(idx_r);
      default: unit_step = CW'(1);
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    cap_nxt       = cap_r;
    ecap_nxt      = ecap_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = rp_r;
    ld            = 1'b0;
    ld_byte       = '0;
    ld_ok         = 1'b0;
    ld_done       = '0;
    ld_last       = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_LEN;
        end
      end

      // run length for peek and drop, capped at the fill level (peek also at MAX_PEEK)
      S_LEN: begin
        len_nxt = (fill_r < amt_ext) ? fill_r : amt_ext;
        if (req_r == REQ_PEEK && len_nxt > MAXP_C) begin
          len_nxt = MAXP_C;
        end
        state_nxt = S_ACT;
      end

      S_ACT: begin
        state_nxt = S_OUT;
        ld        = 1'b1;
        case (req_r)
          REQ_PUSH: begin
            if (fill_r < ecap_r) begin
              mem_we   = 1'b1;
              wp_nxt   = unit_res;
              fill_nxt = fill_r + CW'(1);
              ld_ok    = 1'b1;
              ld_done  = CW'(1);
            end
          end
          REQ_POP: begin
            if (fill_r != '0) begin
              mem_re    = 1'b1;
              rp_nxt    = unit_res;
              fill_nxt  = fill_r - CW'(1);
              len_nxt   = CW'(1);
              idx_nxt   = '0;
              ld        = 1'b0;
              state_nxt = S_READ;
            end
          end
          REQ_PEEK: begin
            if (len_r != '0) begin
              mem_re    = 1'b1;
              idx_nxt   = '0;
              ld        = 1'b0;
              state_nxt = S_READ;
            end
          end
          REQ_DROP: begin
            rp_nxt   = unit_res;
            fill_nxt = fill_r - len_r;
            ld_ok    = (len_r != '0);
            ld_done  = len_r;
          end
          REQ_CLEAR: begin
            rp_nxt   = '0;
            wp_nxt   = '0;
            fill_nxt = '0;
            ld_ok    = 1'b1;
          end
          default: ld_ok = 1'b0;
        endcase
      end

      // next peek address through the wrap unit
      S_ADDR: begin
        mem_re    = 1'b1;
        mem_raddr = unit_res;
        state_nxt = S_READ;
      end

      S_READ: begin
        ld        = 1'b1;
        ld_byte   = rdata_r;
        ld_ok     = 1'b1;
        ld_done   = len_r;
        ld_last   = at_last;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_ADDR;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (ld) begin
      out_valid_nxt = 1'b1;
    end

    // capacity write empties the fifo; the user must write only while idle, not enforced here
    if (cfg_wr) begin
      cap_nxt  = cfg_pwdata[CNT_F_W-1:0];
      ecap_nxt = (wcap == '0) ? CW'(1) : ((wcap > DEPTH_C) ? DEPTH_C : wcap);
      rp_nxt   = '0;
      wp_nxt   = '0;
      fill_nxt = '0;
    end
  end

  // result word, flags taken from the fill level after the request
  always_comb begin
    ld_word                             = '0;
    ld_word[OD_BYTE_LSB +: BYTE_W]      = ld_byte;
    ld_word[OD_OK]                      = ld_ok;
    ld_word[OD_DONE_LSB +: CNT_F_W]     = ld_done[CNT_F_W-1:0];
    ld_word[OD_LEVEL_LSB +: CNT_F_W]    = fill_nxt[CNT_F_W-1:0];
    ld_word[OD_FULL]                    = (fill_nxt == ecap_r);
    ld_word[OD_EMPTY]                   = (fill_nxt == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      cap_r       <= CNT_F_W'(256);
      ecap_r      <= RST_ECAP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      cap_r       <= cap_nxt;
      ecap_r      <= ecap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and run registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r  <= in_tuser;
      byte_r <= in_tdata[ID_BYTE_LSB +: BYTE_W];
      amt_r  <= in_tdata[ID_AMT_LSB +: CNT_F_W];
    end
    len_r <= len_nxt;
    idx_r <= idx_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (ld) begin
      out_data_r <= ld_word;
      out_last_r <= ld_last;
    end
  end

  // storage array, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= byte_r;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

endmodule
`default_nettype wire

### src/brf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_checker
// port level checks on the byte ring fifo, bound to the top level
// ----------------------------------------------------------------------------
module brf_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [brf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                           out_tlast
);

  import brf_pkg::*;

  // no new request while a result is still pending
  a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while result pending");

  // a request always blocks the input for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready right after accepting a request");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)
                                     && $stable(out_tlast)))
    else $error("stalled result changed");

  // empty flag matches the level
  a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OD_EMPTY]
                    == (out_tdata[OD_LEVEL_LSB +: CNT_F_W] == '0)))
    else $error("empty flag disagrees with level");

  // a failed request moves nothing
  a_fail_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[OD_OK]) |-> (out_tdata[OD_DONE_LSB +: CNT_F_W] == '0))
    else $error("failed request reports a count");

endmodule

bind byte_ring_fifo_with_peek_drop brf_checker u_brf_checker (.*);
`default_nettype wire
